// ===== design/b64e_pkg.sv =====
// Shared types and constants for the base64 byte stream encoder.
// Holds the front-to-back job record and the alphabet lookup.
// No dependencies.
package b64e_pkg;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  localparam logic [1:0] PH0 = 2'd0;
  localparam logic [1:0] PH1 = 2'd1;
  localparam logic [1:0] PH2 = 2'd2;

  // characters caused by one byte: up to four six-bit groups or pads
  typedef struct packed {
    logic [3:0][5:0] grp;
    logic [3:0]      pad;
    logic [1:0]      last;   // index of the last character
    logic            fin;
  } job_t;

  function automatic logic [6:0] b64_char(input logic [5:0] six);
    logic [6:0] s;
    s = {1'b0, six};
    if (six < 6'd26) begin
      b64_char = s + 7'd65;
    end else if (six < 6'd52) begin
      b64_char = s + 7'd71;
    end else if (six < 6'd62) begin
      b64_char = s - 7'd4;
    end else if (six == 6'd62) begin
      b64_char = 7'd43;
    end else begin
      b64_char = 7'd47;
    end
  endfunction

endpackage

// ===== design/b64e_front.sv =====
// Front end: takes bytes, keeps leftover bits and byte phase, builds a job.
// Depends on b64e_pkg.
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic [3:0] leftover;
  logic [3:0] leftover_next;
  logic [1:0] phase;
  logic [1:0] phase_next;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_job      = '0;
    push_job.fin  = final_byte;
    leftover_next = leftover;
    phase_next    = phase;
    unique case (phase)
      PH1: begin
        push_job.grp[0] = {leftover[1:0], data_byte[7:4]};
        push_job.grp[1] = {data_byte[3:0], 2'b00};
        push_job.pad[2] = 1'b1;
        push_job.last   = final_byte ? 2'd2 : 2'd0;
        leftover_next   = data_byte[3:0];
        phase_next      = PH2;
      end
      PH2: begin
        push_job.grp[0] = {leftover[3:0], data_byte[7:6]};
        push_job.grp[1] = data_byte[5:0];
        push_job.last   = 2'd1;
        leftover_next   = 4'd0;
        phase_next      = PH0;
      end
      default: begin
        // phase zero, and the unreachable phase three treated alike
        push_job.grp[0] = data_byte[7:2];
        push_job.grp[1] = {data_byte[1:0], 4'b0000};
        push_job.pad[2] = 1'b1;
        push_job.pad[3] = 1'b1;
        push_job.last   = final_byte ? 2'd3 : 2'd0;
        leftover_next   = {2'b00, data_byte[1:0]};
        phase_next      = PH1;
      end
    endcase
    if (final_byte) begin
      leftover_next = 4'd0;
      phase_next    = PH0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover <= 4'd0;
      phase    <= PH0;
    end else if (push) begin
      leftover <= leftover_next;
      phase    <= phase_next;
    end
  end

endmodule

// ===== design/b64e_queue.sv =====
// Two-entry job queue between front and back ends.
// Depends on b64e_pkg.
module b64e_queue
  import b64e_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== design/b64e_back.sv =====
// Back end: walks the head job one character a cycle, while out_stall is low, into the output register.
// Depends on b64e_pkg.
module b64e_back
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] symbol,
  output logic       run_end,
  output logic       message_end
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign load    = (!out_valid || !out_stall) && !empty;
  assign is_last = (idx == head.last);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !empty;
      if (!empty) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      symbol      <= head.pad[idx] ? PAD_CHAR : b64_char(head.grp[idx]);
      run_end     <= is_last;
      message_end <= is_last && head.fin;
    end
  end

endmodule

// ===== design/base64_byte_stream_encoder_core.sv =====
// Base64 (padded) byte stream encoder, top level.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
//   channel  valid      stall      payload
//   in       in_valid   in_stall   data_byte, final_byte
//   out      out_valid  out_stall  symbol, run_end, message_end
//
// One character leaves per cycle while out_stall is low; a byte yields one to four, so a
// message gives four characters per three bytes, plus padding on the final byte.
// A byte's first character reaches the output through the job queue, then the output register.
// Bytes are taken while the two-entry job queue has room; out_stall holds
// the output register and backs up through the queue to in_stall.
// Synchronous reset clears phase, leftover bits, queue and output valid.
module base64_byte_stream_encoder_core
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] symbol,
  output logic       run_end,
  output logic       message_end
);

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  job_t head;
  logic q_empty;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .run_end     (run_end),
    .message_end (message_end)
  );

endmodule

// ===== tb/base64_byte_stream_encoder_core_tb.sv =====
// Self-checking testbench for base64_byte_stream_encoder_core: bytes go in, padded base64 comes out.
// An in-bench scoreboard predicts every character and compares it with the block's output.
// Depends on b64e_pkg and the design sources only.
module base64_byte_stream_encoder_core_tb
  import b64e_pkg::*;
();

  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [6:0] sym;
    logic       run_end;
    logic       msg_end;
  } glyph_t;

  // Tracks message phase and carried bits, queues the characters each byte should produce.
  class b64_scoreboard;
    glyph_t     want_q[$];
    logic [3:0] carry;
    logic [1:0] phase;
    int         errors;
    int         checked;

    function new();
      carry   = '0;
      phase   = PH0;
      errors  = 0;
      checked = 0;
    endfunction

    function glyph_t group_char(input logic [5:0] six);
      glyph_t g;
      g.sym     = B64_ALPHABET[8*(63-six) +: 7];
      g.run_end = 1'b0;
      g.msg_end = 1'b0;
      return g;
    endfunction

    function void note_byte(input logic [7:0] b, input logic fin);
      glyph_t     run [4];
      glyph_t     pad;
      logic [9:0] v10;
      logic [11:0] v12;
      int         n;
      pad = '{sym: PAD_CHAR, run_end: 1'b0, msg_end: 1'b0};
      n = 0;
      case (phase)
        PH1: begin
          v10 = {carry[1:0], b};
          run[n++] = group_char(v10[9:4]);
          carry = b[3:0];
          phase = PH2;
          if (fin) begin
            run[n++] = group_char({carry, 2'b00});
            run[n++] = pad;
          end
        end
        PH2: begin
          v12 = {carry, b};
          run[n++] = group_char(v12[11:6]);
          run[n++] = group_char(v12[5:0]);
          carry = '0;
          phase = PH0;
        end
        default: begin
          // phase three cannot occur; treated as a fresh message
          run[n++] = group_char(b[7:2]);
          carry = {2'b00, b[1:0]};
          phase = PH1;
          if (fin) begin
            run[n++] = group_char({b[1:0], 4'b0000});
            run[n++] = pad;
            run[n++] = pad;
          end
        end
      endcase
      run[n-1].run_end = 1'b1;
      if (fin) begin
        run[n-1].msg_end = 1'b1;
        carry = '0;
        phase = PH0;
      end
      for (int i = 0; i < n; i++) want_q.insert(want_q.size(), run[i]);
    endfunction

    function void check_char(input logic [6:0] sym, input logic re, input logic me);
      glyph_t w;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual symbol %h run_end %b message_end %b",
                 $time, sym, re, me);
        errors++;
        return;
      end
      w = want_q.pop_front();
      checked++;
      if (sym !== w.sym) begin
        $display("%0t: symbol mismatch: expected %h, actual %h", $time, w.sym, sym);
        errors++;
      end
      if (re !== w.run_end) begin
        $display("%0t: run_end mismatch: expected %b, actual %b", $time, w.run_end, re);
        errors++;
      end
      if (me !== w.msg_end) begin
        $display("%0t: message_end mismatch: expected %b, actual %b", $time, w.msg_end, me);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       final_byte;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] symbol;
  logic       run_end;
  logic       message_end;

  b64_scoreboard sb;
  int hold_left;
  bit rx_quiet;
  int bytes_sent;
  int msgs_sent;

  base64_byte_stream_encoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol     (symbol),
    .run_end    (run_end),
    .message_end(message_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("base64_byte_stream_encoder_core_tb: FAIL");
    $finish;
  end

  // Output side: random stalls, a quiet stretch, and a counted hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 17);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_char(symbol, run_end, message_end);
    end
  end

  // Called just after a falling edge; returns just after the falling edge following acceptance.
  task automatic send_byte(input logic [7:0] d, input logic f, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= d;
    final_byte <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(d, f);
    bytes_sent++;
    if (f) msgs_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len, input bit idle);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1,
                (idle && $urandom_range(0, 99) < 17) ? $urandom_range(1, 4) : 0);
    end
  endtask

  task automatic drain_output();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.want_q.size() != 0);
  endtask

  initial begin
    int target;
    int len;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    data_byte  = '0;
    final_byte = 1'b0;
    hold_left  = 0;
    rx_quiet   = 1'b0;
    bytes_sent = 0;
    msgs_sent  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one-byte messages: two pads each
    send_byte(8'h00, 1'b1, 0);
    send_byte(8'hFF, 1'b1, 0);
    send_byte(8'h80, 1'b1, 0);
    // two-byte messages: one pad
    send_byte(8'hFF, 1'b0, 0);
    send_byte(8'hFF, 1'b1, 0);
    send_byte(8'h55, 1'b0, 0);
    send_byte(8'hAA, 1'b1, 0);
    // three-byte messages: no padding, alphabet extremes
    send_byte(8'h00, 1'b0, 0);
    send_byte(8'h00, 1'b0, 0);
    send_byte(8'h00, 1'b1, 0);
    send_byte(8'hFF, 1'b0, 0);
    send_byte(8'hFF, 1'b0, 0);
    send_byte(8'hFF, 1'b1, 0);
    send_byte(8'hFB, 1'b0, 0);
    send_byte(8'hEF, 1'b0, 0);
    send_byte(8'hBE, 1'b1, 0);
    send_byte(8'h4D, 1'b0, 0);
    send_byte(8'h61, 1'b0, 0);
    send_byte(8'h6E, 1'b1, 0);
    // four bytes: wraps past phase two into a fresh group
    send_byte(8'h01, 1'b0, 0);
    send_byte(8'h02, 1'b0, 0);
    send_byte(8'h03, 1'b0, 0);
    send_byte(8'h04, 1'b1, 0);

    while (bytes_sent < 100)
      send_message(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9), 1);

    // input pause until the output has caught up
    drain_output();

    rx_quiet = 1'b1;
    target = bytes_sent + 40;
    while (bytes_sent < target) send_message($urandom_range(1, 9), 0);
    rx_quiet = 1'b0;

    // output held off while input keeps coming, so the block backs up
    hold_left = HOLD_CYCLES;
    target = bytes_sent + 20;
    while (bytes_sent < target) send_message($urandom_range(1, 9), 0);

    while (bytes_sent < 220) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
      if (len > 220 - bytes_sent) len = 220 - bytes_sent;
      send_message(len, 1);
    end

    drain_output();
    repeat (8) @(negedge clk);

    $display("Encoded %0d bytes in %0d messages, %0d characters checked.",
             bytes_sent, msgs_sent, sb.checked);
    $display("Run included random stalls both sides, a stall-free stretch, an output hold-off and a drain pause.");
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("base64_byte_stream_encoder_core_tb: PASS");
    end else begin
      $display("base64_byte_stream_encoder_core_tb: FAIL");
    end
    $finish;
  end

endmodule
